### hdl/srtdc_pkg.sv
// ---------------------------------------------------------------------------
// srtdc_pkg: shared types and constants for the 128-bit key sorter
// Holds the cell record, the drain state type and the key ordering function.
// ---------------------------------------------------------------------------
package srtdc_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int HALF_W       = 64;
    localparam int COUNT_W      = 7;
    localparam int S_DATA_W     = 128;
    localparam int M_DATA_W     = 136;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    localparam logic MODE_COUNT = 1'b0;
    localparam logic MODE_LIST  = 1'b1;

    typedef struct packed {
        logic              valid;
        logic [HALF_W-1:0] upper;
        logic [HALF_W-1:0] lower;
    } cell_t;

    typedef enum logic {
        ST_IDLE,
        ST_DRAIN
    } state_t;

    // True when key a orders strictly before key b, upper half first.
    function automatic logic key_less(input cell_t a, input cell_t b);
        logic res;
        if (a.upper != b.upper)
        begin
            res = (a.upper < b.upper);
        end
        else
        begin
            res = (a.lower < b.lower);
        end
        return res;
    endfunction

endpackage

### hdl/srtdc_cell.sv
// ---------------------------------------------------------------------------
// srtdc_cell: one slot of the insertion chain
// Holds one key. On a load it keeps its key, takes the new key or takes the
// key of the cell below; on a drain shift it takes the key of the cell above.
// ---------------------------------------------------------------------------
module srtdc_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            load,
    input  logic            shift,
    input  srtdc_pkg::cell_t new_key,
    input  srtdc_pkg::cell_t prev_cell,
    input  logic            prev_lt,
    input  srtdc_pkg::cell_t next_cell,
    output srtdc_pkg::cell_t key_out,
    output logic            lt
);
    import srtdc_pkg::*;

    logic              valid_reg;
    logic [HALF_W-1:0] upper_reg;
    logic [HALF_W-1:0] lower_reg;
    cell_t             cell_next;

    assign key_out = {valid_reg, upper_reg, lower_reg};

    // An empty cell counts as larger than any key, so lt is a suffix of ones.
    assign lt = !valid_reg || key_less(new_key, key_out);

    always_comb
    begin
        cell_next = key_out;
        if (load && lt)
        begin
            cell_next = prev_lt ? prev_cell : new_key;
        end
        else if (shift)
        begin
            cell_next = next_cell;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= cell_next.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        upper_reg <= cell_next.upper;
        lower_reg <= cell_next.lower;
    end

endmodule

### hdl/sorter_128bit_keys_distinct_count.sv
// ---------------------------------------------------------------------------
// sorter_128bit_keys_distinct_count: systolic insertion sorter
// Keeps up to CAPACITY keys sorted in a chain of cells and on a finish beat
// either streams them out in order or reports the distinct upper-half count.
// ---------------------------------------------------------------------------
//  channel  direction  signals                    contents
//  s_*      in         s_tvalid/tready/tdata/user  tuser[0] operation,
//                                                  tdata key_upper, key_lower
//  m_*      out        m_tvalid/tready/tdata/user  tdata out_upper, out_lower,
//                      m_tlast                     distinct_count; tuser
//                                                  has_entry, overflowed
//  cfg_*    in         cfg_we, cfg_wdata           output_mode
//
//  Loads may follow back to back.
//  A finish beat drains the chain one cell per cycle, held by output stalls in
//  list mode; in count mode stalls hold only the final result. List mode gives N
//  results (one empty result if N is 0), count mode one; N = number of stored keys.
//  Reset empties the chain at once; no clearing pass is needed.
//  s_tready is low while a finish is being drained.
// ---------------------------------------------------------------------------
module sorter_128bit_keys_distinct_count #(
    parameter int CAPACITY = srtdc_pkg::CAPACITY_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [63:0] key_upper, [127:64] key_lower
    input  logic [srtdc_pkg::S_DATA_W-1:0]  s_tdata,
    // [0] operation
    input  logic [0:0]                      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [63:0] out_upper, [127:64] out_lower, [134:128] distinct_count, [135] zero
    output logic [srtdc_pkg::M_DATA_W-1:0]  m_tdata,
    // [0] has_entry, [1] overflowed
    output logic [1:0]                      m_tuser,
    output logic                            m_tlast,
    input  logic                            cfg_we,
    input  logic                            cfg_wdata
);
    import srtdc_pkg::*;

    cell_t  cell_q [CAPACITY];
    logic   lt_q   [CAPACITY];
    cell_t  new_key;

    state_t state_reg;
    state_t state_next;

    logic               mode_reg;
    logic               overflow_reg;
    logic [COUNT_W-1:0] cnt_reg;
    logic [COUNT_W-1:0] cnt_next;
    logic [HALF_W-1:0]  prev_upper_reg;

    logic               m_valid_reg;
    logic [HALF_W-1:0]  out_upper_reg;
    logic [HALF_W-1:0]  out_lower_reg;
    logic [COUNT_W-1:0] out_count_reg;
    logic               out_has_reg;
    logic               out_ovf_reg;
    logic               out_last_reg;

    logic               accept;
    logic               full;
    logic               ins;
    logic               drop;
    logic               out_free;
    logic               shift;
    logic               emit;
    logic               done;
    logic [HALF_W-1:0]  emit_upper;
    logic [HALF_W-1:0]  emit_lower;
    logic [COUNT_W-1:0] emit_count;
    logic               emit_has;
    logic               emit_last;

    assign new_key.valid = 1'b1;
    assign new_key.upper = s_tdata[HALF_W-1:0];
    assign new_key.lower = s_tdata[2*HALF_W-1:HALF_W];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign full     = cell_q[CAPACITY-1].valid;
    assign ins      = accept && (s_tuser[0] == OP_LOAD) && !full;
    assign drop     = accept && (s_tuser[0] == OP_LOAD) && full;
    assign out_free = !m_valid_reg || m_tready;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            cell_t prev_c;
            cell_t next_c;
            logic  prev_l;
            if (gi == 0)
            begin : g_first
                assign prev_c = '0;
                assign prev_l = 1'b0;
            end
            else
            begin : g_mid
                assign prev_c = cell_q[gi-1];
                assign prev_l = lt_q[gi-1];
            end
            if (gi == CAPACITY - 1)
            begin : g_top
                assign next_c = '0;
            end
            else
            begin : g_low
                assign next_c = cell_q[gi+1];
            end
            srtdc_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .load      (ins),
                .shift     (shift),
                .new_key   (new_key),
                .prev_cell (prev_c),
                .prev_lt   (prev_l),
                .next_cell (next_c),
                .key_out   (cell_q[gi]),
                .lt        (lt_q[gi])
            );
        end
    endgenerate

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (s_tuser[0] == OP_FINISH))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Drain control and result formation.
    always_comb
    begin
        shift      = 1'b0;
        emit       = 1'b0;
        done       = 1'b0;
        emit_upper = '0;
        emit_lower = '0;
        emit_count = '0;
        emit_has   = 1'b0;
        emit_last  = 1'b0;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
            end
            ST_DRAIN:
            begin
                if (mode_reg == MODE_LIST)
                begin
                    if (out_free)
                    begin
                        emit = 1'b1;
                        if (cell_q[0].valid)
                        begin
                            shift      = 1'b1;
                            emit_upper = cell_q[0].upper;
                            emit_lower = cell_q[0].lower;
                            emit_has   = 1'b1;
                            emit_last  = !cell_q[1].valid;
                            done       = !cell_q[1].valid;
                        end
                        else
                        begin
                            emit_last = 1'b1;
                            done      = 1'b1;
                        end
                    end
                end
                else
                begin
                    if (cell_q[0].valid)
                    begin
                        shift = 1'b1;
                        if ((cnt_reg == '0) || (cell_q[0].upper != prev_upper_reg))
                        begin
                            cnt_next = cnt_reg + COUNT_W'(1);
                        end
                    end
                    else if (out_free)
                    begin
                        emit       = 1'b1;
                        emit_count = cnt_reg;
                        emit_has   = 1'b1;
                        emit_last  = 1'b1;
                        done       = 1'b1;
                        cnt_next   = '0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            mode_reg     <= MODE_COUNT;
            overflow_reg <= 1'b0;
            cnt_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (cfg_we)
            begin
                mode_reg <= cfg_wdata;
            end
            if (drop)
            begin
                overflow_reg <= 1'b1;
            end
            else if (done)
            begin
                overflow_reg <= 1'b0;
            end
            if (emit)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            prev_upper_reg <= cell_q[0].upper;
        end
        if (emit)
        begin
            out_upper_reg <= emit_upper;
            out_lower_reg <= emit_lower;
            out_count_reg <= emit_count;
            out_has_reg   <= emit_has;
            out_ovf_reg   <= overflow_reg;
            out_last_reg  <= emit_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, out_count_reg, out_lower_reg, out_upper_reg};
    assign m_tuser  = {out_ovf_reg, out_has_reg};
    assign m_tlast  = out_last_reg;

endmodule

### verif/sorter_checker.sv
// ---------------------------------------------------------------------------
// sorter_checker: prediction and comparison for the 128-bit key sorter
// Watches the input, output and mode write port of the sorter, keeps its own
// sorted copy of the loaded keys, and checks every output beat against the
// oldest predicted drain beat.
// ---------------------------------------------------------------------------
module sorter_checker #(
    parameter int CAPACITY = srtdc_pkg::CAPACITY_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    // [63:0] key_upper, [127:64] key_lower
    input  logic [srtdc_pkg::S_DATA_W-1:0]  s_tdata,
    // [0] operation
    input  logic [0:0]                      s_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    // [63:0] out_upper, [127:64] out_lower, [134:128] distinct_count
    input  logic [srtdc_pkg::M_DATA_W-1:0]  m_tdata,
    // [0] has_entry, [1] overflowed
    input  logic [1:0]                      m_tuser,
    input  logic                            m_tlast,
    input  logic                            cfg_we,
    input  logic                            cfg_wdata,
    output int                              fail_count,
    output int                              pending
);
    import srtdc_pkg::*;

    typedef struct packed {
        logic [HALF_W-1:0]  upper;
        logic [HALF_W-1:0]  lower;
        logic [COUNT_W-1:0] distinct;
        logic               has_entry;
        logic               overflowed;
        logic               last;
    } drain_beat_t;

    // Each entry is {upper, lower}, so a plain unsigned compare gives key order.
    logic [2*HALF_W-1:0] sorted_keys[$];
    drain_beat_t         drain_q[$];
    logic                dropped_key;
    logic                mode;
    int                  errors = 0;

    task automatic store_key(input logic [HALF_W-1:0] up, input logic [HALF_W-1:0] lo);
        int pos;
        if (sorted_keys.size() >= CAPACITY)
        begin
            dropped_key = 1'b1;
        end
        else
        begin
            // Equal keys stay ahead of the new one.
            pos = sorted_keys.size();
            while (pos > 0 && {up, lo} < sorted_keys[pos-1])
            begin
                pos--;
            end
            sorted_keys.insert(pos, {up, lo});
        end
    endtask

    task automatic predict_finish();
        drain_beat_t b;
        int          distinct;
        b = '0;
        b.overflowed = dropped_key;
        if (mode == MODE_LIST)
        begin
            if (sorted_keys.size() == 0)
            begin
                b.last = 1'b1;
                drain_q.push_back(b);
            end
            foreach (sorted_keys[i])
            begin
                b.upper     = sorted_keys[i][2*HALF_W-1:HALF_W];
                b.lower     = sorted_keys[i][HALF_W-1:0];
                b.has_entry = 1'b1;
                b.last      = (i == sorted_keys.size() - 1);
                drain_q.push_back(b);
            end
        end
        else
        begin
            distinct = 0;
            foreach (sorted_keys[i])
            begin
                if (i == 0 || sorted_keys[i][2*HALF_W-1:HALF_W]
                              != sorted_keys[i-1][2*HALF_W-1:HALF_W])
                begin
                    distinct++;
                end
            end
            b.distinct  = distinct[COUNT_W-1:0];
            b.has_entry = 1'b1;
            b.last      = 1'b1;
            drain_q.push_back(b);
        end
        sorted_keys.delete();
        dropped_key = 1'b0;
    endtask

    task automatic check_field(input string name, input logic [HALF_W-1:0] exp_v,
                               input logic [HALF_W-1:0] act_v);
        if (act_v !== exp_v)
        begin
            $error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        drain_beat_t exp_b;
        if (!rst_n)
        begin
            sorted_keys.delete();
            drain_q.delete();
            dropped_key = 1'b0;
            mode        = MODE_COUNT;
            pending    <= 0;
            fail_count <= errors;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (drain_q.size() == 0)
                begin
                    $error("output beat with no expected result: tdata %0h", m_tdata);
                    errors++;
                end
                else
                begin
                    exp_b = drain_q.pop_front();
                    check_field("out_upper", exp_b.upper, m_tdata[HALF_W-1:0]);
                    check_field("out_lower", exp_b.lower, m_tdata[2*HALF_W-1:HALF_W]);
                    check_field("distinct_count", 64'(exp_b.distinct),
                                64'(m_tdata[2*HALF_W+COUNT_W-1:2*HALF_W]));
                    check_field("has_entry", 64'(exp_b.has_entry), 64'(m_tuser[0]));
                    check_field("overflowed", 64'(exp_b.overflowed), 64'(m_tuser[1]));
                    check_field("last", 64'(exp_b.last), 64'(m_tlast));
                end
            end
            if (cfg_we)
            begin
                mode = cfg_wdata;
            end
            if (s_tvalid && s_tready)
            begin
                if (s_tuser[0] == OP_FINISH)
                begin
                    predict_finish();
                end
                else
                begin
                    store_key(s_tdata[HALF_W-1:0], s_tdata[2*HALF_W-1:HALF_W]);
                end
            end
            pending    <= drain_q.size();
            fail_count <= errors;
        end
    end

endmodule

### verif/testbench.sv
// ---------------------------------------------------------------------------
// testbench: stimulus and verdict for the 128-bit key sorter
// Runs directed loads and finishes in both output modes, then random batches
// of keys with random input gaps and output stalls; a checker module predicts
// and compares every output beat.
// ---------------------------------------------------------------------------
module testbench;
    import srtdc_pkg::*;

    localparam int CAPACITY      = CAPACITY_DEF;
    localparam int RANDOM_ITEMS  = 230;
    localparam int SETTLE_CYCLES = CAPACITY + 8;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata   = '0;
    logic [0:0]           s_tuser   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_DATA_W-1:0]  m_tdata;
    logic [1:0]           m_tuser;
    logic                 m_tlast;
    logic                 cfg_we    = 1'b0;
    logic                 cfg_wdata = 1'b0;

    int   fail_count;
    int   pending;
    logic gaps_on    = 1'b0;
    logic stalls_on  = 1'b0;
    int   stall_left = 0;
    int   items_sent = 0;

    always #5 clk = ~clk;

    sorter_128bit_keys_distinct_count #(
        .CAPACITY (CAPACITY)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    sorter_checker #(
        .CAPACITY (CAPACITY)
    ) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        if ($urandom_range(0, 7) == 0)
        begin
            return $urandom_range(10, 40);
        end
        return $urandom_range(1, 3);
    endfunction

    // Narrow value sets make equal upper halves and equal keys common.
    function automatic logic [HALF_W-1:0] rand_half(input logic full_range);
        if (full_range || $urandom_range(0, 3) == 0)
        begin
            return {$urandom, $urandom};
        end
        case ($urandom_range(0, 3))
            0: return '0;
            1: return '1;
            2: return HALF_W'($urandom_range(0, 3));
            default: return 64'h8000_0000_0000_0000;
        endcase
    endfunction

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (stalls_on && $urandom_range(0, 3) == 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= pick_gap() - 1;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    task automatic drive_beat(input logic op, input logic [HALF_W-1:0] up,
                              input logic [HALF_W-1:0] lo);
        int gap;
        gap = (gaps_on && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {lo, up};
        s_tuser  <= op;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
    endtask

    // Drops valid, waits for every predicted beat, then lets the sorter settle.
    task automatic drain_and_settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_mode(input logic value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic load_edge_keys();
        drive_beat(OP_LOAD, '0, '0);
        drive_beat(OP_LOAD, '1, '1);
        drive_beat(OP_LOAD, '1, '0);
        drive_beat(OP_LOAD, '0, '1);
        drive_beat(OP_LOAD, 64'd5, 64'd7);
        drive_beat(OP_LOAD, 64'd5, 64'd3);
        drive_beat(OP_LOAD, 64'd5, 64'd7);
    endtask

    initial
    begin
        int   phase;
        int   batch;
        int   n_keys;
        logic wide_upper;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Count mode out of reset: empty store, then edge keys with duplicates.
        drive_beat(OP_FINISH, '1, '1);
        load_edge_keys();
        drive_beat(OP_FINISH, '0, '0);
        drain_and_settle();

        // List mode: empty store, then the same keys, finish key fields ignored.
        write_mode(MODE_LIST);
        drive_beat(OP_FINISH, '0, '0);
        load_edge_keys();
        drive_beat(OP_FINISH, '1, '1);
        drain_and_settle();

        phase = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            case (phase)
                0: write_mode(MODE_COUNT);
                1: write_mode(MODE_LIST);
                2: write_mode(MODE_COUNT);
                default: write_mode(logic'($urandom_range(0, 1)));
            endcase
            gaps_on   <= (phase % 3 != 0);
            stalls_on <= (phase % 3 != 1);
            for (batch = 0; batch < int'($urandom_range(2, 5)); batch++)
            begin
                wide_upper = logic'($urandom_range(0, 1));
                if (batch == 0 && phase == 1)
                begin
                    // Exactly full store in list mode.
                    n_keys = CAPACITY;
                end
                else if (batch == 0 && phase == 2)
                begin
                    // Overflow in count mode, distinct uppers up to the limit.
                    n_keys     = CAPACITY + 2;
                    wide_upper = 1'b1;
                end
                else if ($urandom_range(0, 11) == 0)
                begin
                    n_keys = $urandom_range(CAPACITY - 4, CAPACITY + 4);
                end
                else
                begin
                    n_keys = $urandom_range(0, 9);
                end
                repeat (n_keys)
                begin
                    drive_beat(OP_LOAD, rand_half(wide_upper), rand_half(1'b0));
                    items_sent++;
                end
                drive_beat(OP_FINISH, {$urandom, $urandom}, {$urandom, $urandom});
                items_sent++;
            end
            drain_and_settle();
            phase++;
        end

        if (fail_count == 0 && pending == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

### filelist.f
hdl/srtdc_pkg.sv
hdl/srtdc_cell.sv
hdl/sorter_128bit_keys_distinct_count.sv
verif/sorter_checker.sv
verif/testbench.sv
